/* hw/rtl/lrut_pkg.sv */
// ----------------------------------------------------------------------------
// lrut_pkg
// Shared types and constants of the timestamp-ordered replacement table.
// ----------------------------------------------------------------------------
package lrut_pkg;

   localparam int ENTRIES_DEFAULT = 8;
   localparam int VALUE_W         = 32;
   localparam int AGE_W           = 32;
   localparam int KIND_W          = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_DUMP   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic scan_init;
      logic scan_step;
      logic commit_insert;
      logic commit_remove;
      logic commit_dump;
   } cmd_type;

   typedef struct packed {
      logic     scan_last;
      logic     dump_last;
      logic     out_free;
      kind_type kind;
   } sts_type;

endpackage

/* hw/rtl/lrut_ctrl.sv */
// ----------------------------------------------------------------------------
// lrut_ctrl
// Sequencer: accepts a transaction, runs the slot scans and commits results.
// ----------------------------------------------------------------------------
module lrut_ctrl import lrut_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic [KIND_W-1:0]   req_tuser,
   output logic                req_tready,
   input  sts_type             sts,
   output cmd_type             cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      kind_ok;

   assign kind_ok = (req_tuser == KIND_INSERT) || (req_tuser == KIND_REMOVE) ||
                    (req_tuser == KIND_DUMP);
   assign accept  = req_tvalid && (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && kind_ok) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            unique case (sts.kind)
               KIND_INSERT: state_in = ST_IDLE;
               KIND_REMOVE: begin
                  if (sts.out_free) begin
                     state_in = ST_IDLE;
                  end
               end
               KIND_DUMP: begin
                  if (sts.out_free) begin
                     state_in = sts.dump_last ? ST_IDLE : ST_SCAN;
                  end
               end
               default: state_in = ST_IDLE;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (accept && kind_ok) begin
               cmd.start     = 1'b1;
               cmd.scan_init = 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_COMMIT: begin
            unique case (sts.kind)
               KIND_INSERT: cmd.commit_insert = 1'b1;
               KIND_REMOVE: cmd.commit_remove = sts.out_free;
               KIND_DUMP: begin
                  cmd.commit_dump = sts.out_free;
                  cmd.scan_init   = sts.out_free && !sts.dump_last;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/lrut_dpath.sv */
// ----------------------------------------------------------------------------
// lrut_dpath
// Slot storage, sequential minimum search, use counter and result register.
// ----------------------------------------------------------------------------
module lrut_dpath import lrut_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [VALUE_W-1:0]  req_tdata,
   input  logic [KIND_W-1:0]   req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [VALUE_W-1:0]  rsp_tdata,
   output logic                rsp_tlast,
   input  cmd_type             cmd,
   output sts_type             sts
);

   localparam int IW = $clog2(ENTRIES);
   localparam int KW = AGE_W + IW;

   logic [AGE_W-1:0]   age_mem [ENTRIES];
   logic [VALUE_W-1:0] val_mem [ENTRIES];

   kind_type           kind_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [AGE_W-1:0]   counter_ff, counter_in;
   logic [IW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      dump_cnt_ff, dump_cnt_in;
   logic               rd_valid_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic [AGE_W-1:0]   rd_age_ff;
   logic [VALUE_W-1:0] rd_val_ff;
   logic               rd_ok_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic               found_ff, found_in;
   logic [KW-1:0]      best_key_ff, best_key_in;
   logic [VALUE_W-1:0] best_val_ff, best_val_in;
   logic               has_prev_ff, has_prev_in;
   logic [KW-1:0]      prev_key_ff, prev_key_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [KW-1:0]      cand_key;
   logic [VALUE_W-1:0] cand_val;
   logic               eligible;
   logic [IW-1:0]      best_idx;
   logic [AGE_W-1:0]   new_age;

   assign best_idx = best_key_ff[IW-1:0];
   assign new_age  = (counter_ff == '1) ? counter_ff : counter_ff + AGE_W'(1);
   assign cand_key = {(rd_ok_ff ? rd_age_ff : '0), rd_idx_ff};
   assign cand_val = rd_ok_ff ? rd_val_ff : '0;
   assign eligible = !has_prev_ff || (cand_key > prev_key_ff);

   always_comb begin
      counter_in   = counter_ff;
      cnt_in       = cnt_ff;
      dump_cnt_in  = dump_cnt_ff;
      valid_in     = valid_ff;
      found_in     = found_ff;
      best_key_in  = best_key_ff;
      best_val_in  = best_val_ff;
      has_prev_in  = has_prev_ff;
      prev_key_in  = prev_key_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (rd_valid_ff && eligible && (!found_ff || (cand_key < best_key_ff))) begin
         found_in    = 1'b1;
         best_key_in = cand_key;
         best_val_in = cand_val;
      end
      if (cmd.scan_step) begin
         cnt_in = cnt_ff + IW'(1);
      end
      if (cmd.scan_init) begin
         cnt_in   = '0;
         found_in = 1'b0;
      end
      if (cmd.start) begin
         has_prev_in = 1'b0;
         dump_cnt_in = '0;
      end
      if (cmd.commit_insert) begin
         counter_in         = new_age;
         valid_in[best_idx] = 1'b1;
      end
      if (cmd.commit_remove) begin
         valid_in[best_idx] = 1'b0;
         rsp_valid_in       = 1'b1;
         rsp_data_in        = best_val_ff;
         rsp_last_in        = 1'b1;
      end
      if (cmd.commit_dump) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = best_val_ff;
         rsp_last_in  = sts.dump_last;
         has_prev_in  = 1'b1;
         prev_key_in  = best_key_ff;
         dump_cnt_in  = dump_cnt_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) begin
         rd_age_ff <= age_mem[cnt_ff];
         rd_val_ff <= val_mem[cnt_ff];
      end
      if (cmd.commit_insert) begin
         age_mem[best_idx] <= new_age;
         val_mem[best_idx] <= value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         cnt_ff       <= '0;
         dump_cnt_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         valid_ff     <= '0;
         found_ff     <= 1'b0;
         has_prev_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         counter_ff   <= counter_in;
         cnt_ff       <= cnt_in;
         dump_cnt_ff  <= dump_cnt_in;
         rd_valid_ff  <= cmd.scan_step;
         valid_ff     <= valid_in;
         found_ff     <= found_in;
         has_prev_ff  <= has_prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff  <= kind_type'(req_tuser);
         value_ff <= req_tdata;
      end
      if (cmd.scan_step) begin
         rd_idx_ff <= cnt_ff;
         rd_ok_ff  <= valid_ff[cnt_ff];
      end
      best_key_ff <= best_key_in;
      best_val_ff <= best_val_in;
      prev_key_ff <= prev_key_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign sts.scan_last = (cnt_ff == IW'(ENTRIES - 1));
   assign sts.dump_last = (dump_cnt_ff == IW'(ENTRIES - 1));
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;
   assign sts.kind      = kind_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hw/rtl/lru_table_timestamp.sv */
// ----------------------------------------------------------------------------
// lru_table_timestamp
// Table of values replaced in order of their age stamps.
// ----------------------------------------------------------------------------
// The request channel carries the operation in req_tuser and the value to
// insert in req_tdata. An insert writes the value into the slot with the
// smallest stamp and gives no result. A remove returns the oldest value with
// rsp_tlast set and empties that slot. A dump returns all ENTRIES slots from
// oldest to newest, empty slots as zero, with rsp_tlast on the final one.
// Operation code 3 is accepted and ignored.
// Every search reads the slot memory one entry per cycle in the scan state,
// then passes through the drain and commit states. A dump runs one such
// search per result. req_tready is high only between transactions. A result
// waits in the output register while rsp_tready is low; the search in
// progress still completes, but a remove or dump commit holds until the
// register is free. Reset empties every slot and clears the use counter at
// once; no clearing pass follows.
// ----------------------------------------------------------------------------
module lru_table_timestamp import lrut_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [VALUE_W-1:0]  req_tdata,  // value
   input  logic [KIND_W-1:0]   req_tuser,  // kind
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [VALUE_W-1:0]  rsp_tdata,  // value_res
   output logic                rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   lrut_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lrut_dpath #(
      .ENTRIES (ENTRIES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

/* hw/rtl/lrut_checker.sv */
// ----------------------------------------------------------------------------
// lrut_checker
// Port-level checks of the replacement table, bound to the top level.
// ----------------------------------------------------------------------------
module lrut_checker import lrut_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [KIND_W-1:0]   req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [VALUE_W-1:0]  rsp_tdata,
   input logic                rsp_tlast
);

   logic req_fire;
   logic op_valid;

   assign req_fire = req_tvalid && req_tready;
   assign op_valid = (req_tuser == KIND_INSERT) || (req_tuser == KIND_REMOVE) ||
                     (req_tuser == KIND_DUMP);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("Stalled response changed.");

   a_busy_after_op: assert property (@(posedge clock) disable iff (reset)
      req_fire && op_valid |=> !req_tready)
      else $error("New transaction accepted while an operation runs.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("Reset left the block busy.");

   a_no_rsp_while_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("Response appeared without an operation in progress.");

endmodule

bind lru_table_timestamp lrut_checker u_lrut_checker (.*);

/* tb/tb_lru_table_timestamp.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_table_timestamp
// Self-checking testbench of the timestamp-ordered replacement table.
// ----------------------------------------------------------------------------
// Insert, remove, dump and ignored transactions are sent in bursts with
// random gaps while the result side stalls in changing modes. A local copy of
// the slot values, stamps and use counter predicts every result, and each
// received result is checked against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_lru_table_timestamp;
   import lrut_pkg::*;

   localparam int                TABLE_SIZE  = ENTRIES_DEFAULT;
   localparam int                CYCLE_LIMIT = 400000;
   localparam int                SETTLE      = TABLE_SIZE * (TABLE_SIZE + 2) + 20;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               last;
   } table_result_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [VALUE_W-1:0] req_tdata   = '0;  // value
   logic [KIND_W-1:0]  req_tuser   = '0;  // kind
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [VALUE_W-1:0] rsp_tdata;        // value_res
   logic               rsp_tlast;

   logic [VALUE_W-1:0] slot_value [TABLE_SIZE];
   logic [AGE_W-1:0]   slot_age [TABLE_SIZE];
   logic [AGE_W-1:0]   use_count;
   table_result_type   expected_results [$];

   int  mismatches  = 0;
   int  cycle_count = 0;
   int  burst_left  = 0;
   int  stall_left  = 0;
   bit  stall_on    = 1'b0;

   lru_table_timestamp #(.ENTRIES(TABLE_SIZE)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("lru_table_timestamp: mismatch");
      $finish;
   end

   // The receiver is always ready or stalls in random bursts, in a mode picked anew at random.
   always @(posedge clock) begin
      if (cycle_count % 300 == 0) begin
         stall_on <= ($urandom_range(0, 2) != 0);
      end
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (stall_on && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(1, 8);
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] expv,
                                  input logic [VALUE_W-1:0] gotv);
      $display("%0t: %s: expected %h, got %h", $time, what, expv, gotv);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_result
      table_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with none expected", '0, rsp_tdata);
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tdata !== exp_r.value) begin
               report_mismatch("value", exp_r.value, rsp_tdata);
            end
            if (rsp_tlast !== exp_r.last) begin
               report_mismatch("last flag", exp_r.last, rsp_tlast);
            end
         end
      end
   end

   function automatic int oldest_slot();
      int best;
      best = 0;
      for (int i = 1; i < TABLE_SIZE; i++) begin
         if (slot_age[i] < slot_age[best]) best = i;
      end
      return best;
   endfunction

   function automatic void table_apply(input logic [KIND_W-1:0] kind,
                                       input logic [VALUE_W-1:0] value);
      int               slot;
      int               best;
      bit               taken [TABLE_SIZE];
      table_result_type r;
      slot = oldest_slot();
      case (kind)
         KIND_INSERT: begin
            if (use_count != '1) use_count++;
            slot_value[slot] = value;
            slot_age[slot]   = use_count;
         end
         KIND_REMOVE: begin
            r.value = slot_value[slot];
            r.last  = 1'b1;
            expected_results.push_back(r);
            slot_value[slot] = '0;
            slot_age[slot]   = '0;
         end
         KIND_DUMP: begin
            foreach (taken[i]) taken[i] = 1'b0;
            for (int k = 0; k < TABLE_SIZE; k++) begin
               best = -1;
               for (int i = 0; i < TABLE_SIZE; i++) begin
                  if (!taken[i] && (best < 0 || slot_age[i] < slot_age[best])) best = i;
               end
               taken[best] = 1'b1;
               r.value = slot_value[best];
               r.last  = (k == TABLE_SIZE - 1);
               expected_results.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 6))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'hFFFF_FFFF;
         3:       return '0;
         4:       return $urandom_range(1, 16);
         default: return $urandom;
      endcase
   endfunction

   task automatic idle(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic pace();
      if (burst_left == 0) begin
         idle($urandom_range(1, 12));
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 30)
                                               : $urandom_range(0, 4);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [VALUE_W-1:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      table_apply(kind, value);
      pace();
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic test_directed();
      send_request(KIND_REMOVE, $urandom);
      send_request(KIND_DUMP, $urandom);
      send_request(KIND_UNUSED, $urandom);
      send_request(KIND_INSERT, 32'h7FFF_FFFF);
      send_request(KIND_INSERT, 32'h8000_0000);
      send_request(KIND_INSERT, 32'hFFFF_FFFF);
      send_request(KIND_INSERT, 32'h0000_0000);
      send_request(KIND_INSERT, 32'h0000_0001);
      send_request(KIND_INSERT, 32'h7FFF_FFFF);
      send_request(KIND_INSERT, 32'h5555_5555);
      send_request(KIND_INSERT, 32'hAAAA_AAAA);
      wait_results_drained();
      send_request(KIND_INSERT, 32'h1234_5678);
      send_request(KIND_DUMP, 32'hFFFF_FFFF);
      send_request(KIND_REMOVE, 32'hFFFF_FFFF);
      send_request(KIND_REMOVE, '0);
      send_request(KIND_INSERT, 32'hDEAD_BEEF);
      send_request(KIND_UNUSED, 32'hFFFF_FFFF);
      send_request(KIND_DUMP, '0);
      send_request(KIND_REMOVE, $urandom);
      wait_results_drained();
   endtask

   task automatic test_fill_and_drain(input int rounds);
      int fill;
      for (int n = 0; n < rounds; n++) begin
         fill = $urandom_range(1, TABLE_SIZE + 3);
         repeat (fill) send_request(KIND_INSERT, random_value());
         send_request(KIND_DUMP, $urandom);
         repeat (fill + $urandom_range(0, 2)) send_request(KIND_REMOVE, $urandom);
         send_request(KIND_DUMP, $urandom);
      end
      wait_results_drained();
   endtask

   task automatic test_random_mix(input int items);
      int counted;
      int pick;
      counted = 0;
      while (counted < items) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            send_request(KIND_INSERT, random_value());
         end else if (pick < 75) begin
            send_request(KIND_REMOVE, $urandom);
         end else if (pick < 90) begin
            send_request(KIND_DUMP, $urandom);
         end else begin
            send_request(KIND_UNUSED, $urandom);
            counted--;
         end
         counted++;
         if (counted % 50 == 0) wait_results_drained();
      end
      wait_results_drained();
   endtask

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         slot_value[i] = '0;
         slot_age[i]   = '0;
      end
      use_count = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_drain(4);
      test_random_mix(170);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("lru_table_timestamp: match");
      end else begin
         $display("lru_table_timestamp: mismatch");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/lrut_pkg.sv
hw/rtl/lrut_ctrl.sv
hw/rtl/lrut_dpath.sv
hw/rtl/lru_table_timestamp.sv
hw/rtl/lrut_checker.sv
tb/tb_lru_table_timestamp.sv
